// ===== hw/rtl/sbi_pkg.sv =====
package sbi_pkg;

  localparam int COORD_BITS_DEF = 20;
  localparam int NUM_EDGES = 4;

  typedef enum logic {
    FUNC_SEG = 1'b0,
    FUNC_BOX = 1'b1
  } func_t;

endpackage

// ===== hw/rtl/segment_box_intersection.sv =====
// Segment intersection pipeline: each transfer tests segment AB against segment CD
// (func 0) or against all edges of an axis-aligned box (func 1), exactly, using
// cross products and sign/magnitude compares. One item enters per cycle while the
// output does not stall; for a segment hit the point is formed by a restoring divider,
// one quotient bit per stage. A stall while out_valid is high holds the whole pipeline.
module segment_box_intersection #(
  parameter int COORD_BITS = sbi_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         func,
  input  logic signed [COORD_BITS-1:0] seg_ax,
  input  logic signed [COORD_BITS-1:0] seg_ay,
  input  logic signed [COORD_BITS-1:0] seg_bx,
  input  logic signed [COORD_BITS-1:0] seg_by,
  input  logic signed [COORD_BITS-1:0] other_x0,
  input  logic signed [COORD_BITS-1:0] other_y0,
  input  logic signed [COORD_BITS-1:0] other_x1,
  input  logic signed [COORD_BITS-1:0] other_y1,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y
);

  localparam int N   = COORD_BITS;
  localparam int NL  = sbi_pkg::NUM_EDGES;
  localparam int DW  = N + 3;
  localparam int PW  = 2 * DW;
  localparam int CW  = PW + 1;
  localparam int LH  = DW / 2;
  localparam int HH  = DW - LH;
  localparam int PPW = CW + DW;
  localparam int NQ  = N + 1;
  localparam int XW  = PPW + NQ;
  localparam int FW  = N + 3;

  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: differences
  logic signed [DW-1:0] ax_e, ay_e, lx, hx, ly, hy;
  logic signed [DW-1:0] cx [NL];
  logic signed [DW-1:0] cy [NL];
  logic signed [DW-1:0] dx [NL];
  logic signed [DW-1:0] dy [NL];

  always_comb begin
    ax_e = DW'(seg_ax);
    ay_e = DW'(seg_ay);
    lx = DW'(other_x0) - DW'(other_x1);
    hx = DW'(other_x0) + DW'(other_x1);
    ly = DW'(other_y0) - DW'(other_y1);
    hy = DW'(other_y0) + DW'(other_y1);
    if (func == sbi_pkg::FUNC_SEG) begin
      cx[0] = DW'(other_x0);
      cy[0] = DW'(other_y0);
      dx[0] = DW'(other_x1);
      dy[0] = DW'(other_y1);
    end else begin
      cx[0] = lx;
      cy[0] = ly;
      dx[0] = hx;
      dy[0] = ly;
    end
    cx[1] = hx; cy[1] = ly; dx[1] = hx; dy[1] = hy;
    cx[2] = hx; cy[2] = hy; dx[2] = lx; dy[2] = hy;
    cx[3] = lx; cy[3] = hy; dx[3] = lx; dy[3] = ly;
  end

  logic                 v1;
  logic                 s1_func;
  logic signed [N-1:0]  s1_ax, s1_ay;
  logic signed [DW-1:0] s1_rx, s1_ry;
  logic signed [DW-1:0] s1_sx [NL];
  logic signed [DW-1:0] s1_sy [NL];
  logic signed [DW-1:0] s1_qx [NL];
  logic signed [DW-1:0] s1_qy [NL];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_func <= func;
      s1_ax <= seg_ax;
      s1_ay <= seg_ay;
      s1_rx <= DW'(seg_bx) - ax_e;
      s1_ry <= DW'(seg_by) - ay_e;
      for (int l = 0; l < NL; l++) begin
        s1_sx[l] <= dx[l] - cx[l];
        s1_sy[l] <= dy[l] - cy[l];
        s1_qx[l] <= cx[l] - ax_e;
        s1_qy[l] <= cy[l] - ay_e;
      end
    end
  end

  // stage 2: products
  logic                 v2;
  logic                 s2_func;
  logic signed [N-1:0]  s2_ax, s2_ay;
  logic signed [DW-1:0] s2_rx, s2_ry;
  logic signed [PW-1:0] s2_d1 [NL];
  logic signed [PW-1:0] s2_d2 [NL];
  logic signed [PW-1:0] s2_t1 [NL];
  logic signed [PW-1:0] s2_t2 [NL];
  logic signed [PW-1:0] s2_u1 [NL];
  logic signed [PW-1:0] s2_u2 [NL];

  always_ff @(posedge clk) begin
    if (en) begin
      s2_func <= s1_func;
      s2_ax <= s1_ax;
      s2_ay <= s1_ay;
      s2_rx <= s1_rx;
      s2_ry <= s1_ry;
      for (int l = 0; l < NL; l++) begin
        s2_d1[l] <= PW'(s1_rx) * PW'(s1_sy[l]);
        s2_d2[l] <= PW'(s1_ry) * PW'(s1_sx[l]);
        s2_t1[l] <= PW'(s1_qx[l]) * PW'(s1_sy[l]);
        s2_t2[l] <= PW'(s1_qy[l]) * PW'(s1_sx[l]);
        s2_u1[l] <= PW'(s1_qx[l]) * PW'(s1_ry);
        s2_u2[l] <= PW'(s1_qy[l]) * PW'(s1_rx);
      end
    end
  end

  // stage 3: cross products
  logic                 v3;
  logic                 s3_func;
  logic signed [N-1:0]  s3_ax, s3_ay;
  logic signed [DW-1:0] s3_rx, s3_ry;
  logic signed [CW-1:0] s3_den [NL];
  logic signed [CW-1:0] s3_tn  [NL];
  logic signed [CW-1:0] s3_un  [NL];

  always_ff @(posedge clk) begin
    if (en) begin
      s3_func <= s2_func;
      s3_ax <= s2_ax;
      s3_ay <= s2_ay;
      s3_rx <= s2_rx;
      s3_ry <= s2_ry;
      for (int l = 0; l < NL; l++) begin
        s3_den[l] <= CW'(s2_d1[l]) - CW'(s2_d2[l]);
        s3_tn[l]  <= CW'(s2_t1[l]) - CW'(s2_t2[l]);
        s3_un[l]  <= CW'(s2_u1[l]) - CW'(s2_u2[l]);
      end
    end
  end

  // stage 4: hit decision and magnitudes
  logic [NL-1:0] lane_hit;
  logic          any_hit;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      if (s3_den[l] == '0) begin
        lane_hit[l] = 1'b0;
      end else if (!s3_den[l][CW-1]) begin
        lane_hit[l] = (s3_tn[l] >= 0) && (s3_tn[l] <= s3_den[l]) &&
                      (s3_un[l] >= 0) && (s3_un[l] <= s3_den[l]);
      end else begin
        lane_hit[l] = (s3_tn[l] <= 0) && (s3_tn[l] >= s3_den[l]) &&
                      (s3_un[l] <= 0) && (s3_un[l] >= s3_den[l]);
      end
    end
    any_hit = (s3_func == sbi_pkg::FUNC_SEG) ? lane_hit[0] : |lane_hit;
  end

  logic                v4;
  logic                s4_hit, s4_pt;
  logic signed [N-1:0] s4_ax, s4_ay;
  logic [CW-1:0]       s4_dabs, s4_tnp;
  logic [DW-1:0]       s4_arx, s4_ary;
  logic                s4_nx, s4_ny;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_hit <= any_hit;
      s4_pt <= (s3_func == sbi_pkg::FUNC_SEG) && lane_hit[0];
      s4_ax <= s3_ax;
      s4_ay <= s3_ay;
      s4_dabs <= s3_den[0][CW-1] ? CW'(-s3_den[0]) : CW'(s3_den[0]);
      s4_tnp <= s3_den[0][CW-1] ? CW'(-s3_tn[0]) : CW'(s3_tn[0]);
      s4_arx <= s3_rx[DW-1] ? DW'(-s3_rx) : DW'(s3_rx);
      s4_ary <= s3_ry[DW-1] ? DW'(-s3_ry) : DW'(s3_ry);
      s4_nx <= s3_rx[DW-1];
      s4_ny <= s3_ry[DW-1];
    end
  end

  // stage 5: partial products of t numerator and |r|
  logic                v5;
  logic                s5_hit, s5_pt, s5_nx, s5_ny;
  logic signed [N-1:0] s5_ax, s5_ay;
  logic [CW-1:0]       s5_dabs;
  logic [CW+LH-1:0]    s5_lx, s5_ly;
  logic [CW+HH-1:0]    s5_hx, s5_hy;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_hit <= s4_hit;
      s5_pt <= s4_pt;
      s5_nx <= s4_nx;
      s5_ny <= s4_ny;
      s5_ax <= s4_ax;
      s5_ay <= s4_ay;
      s5_dabs <= s4_dabs;
      s5_lx <= (CW+LH)'(s4_tnp) * (CW+LH)'(s4_arx[LH-1:0]);
      s5_ly <= (CW+LH)'(s4_tnp) * (CW+LH)'(s4_ary[LH-1:0]);
      s5_hx <= (CW+HH)'(s4_tnp) * (CW+HH)'(s4_arx[DW-1:LH]);
      s5_hy <= (CW+HH)'(s4_tnp) * (CW+HH)'(s4_ary[DW-1:LH]);
    end
  end

  // stage 6 feeds the divider: entry 0 of the divider arrays
  logic                dvld  [NQ+1];
  logic                d_hit [NQ+1];
  logic                d_pt  [NQ+1];
  logic                d_nx  [NQ+1];
  logic                d_ny  [NQ+1];
  logic signed [N-1:0] d_ax  [NQ+1];
  logic signed [N-1:0] d_ay  [NQ+1];
  logic [CW-1:0]       d_den [NQ+1];
  logic [PPW-1:0]      d_rx  [NQ+1];
  logic [PPW-1:0]      d_ry  [NQ+1];
  logic [NQ-1:0]       d_qx  [NQ+1];
  logic [NQ-1:0]       d_qy  [NQ+1];

  always_ff @(posedge clk) begin
    if (en) begin
      d_hit[0] <= s5_hit;
      d_pt[0] <= s5_pt;
      d_nx[0] <= s5_nx;
      d_ny[0] <= s5_ny;
      d_ax[0] <= s5_ax;
      d_ay[0] <= s5_ay;
      d_den[0] <= s5_dabs;
      d_rx[0] <= PPW'(s5_lx) + (PPW'(s5_hx) << LH);
      d_ry[0] <= PPW'(s5_ly) + (PPW'(s5_hy) << LH);
      d_qx[0] <= '0;
      d_qy[0] <= '0;
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar j = 0; j < NQ; j++) begin : g_div
    logic [XW-1:0] dsh, remx, remy;
    logic          gex, gey;

    always_comb begin
      dsh = XW'(d_den[j]) << (NQ - 1 - j);
      remx = XW'(d_rx[j]);
      remy = XW'(d_ry[j]);
      gex = remx >= dsh;
      gey = remy >= dsh;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_hit[j+1] <= d_hit[j];
        d_pt[j+1] <= d_pt[j];
        d_nx[j+1] <= d_nx[j];
        d_ny[j+1] <= d_ny[j];
        d_ax[j+1] <= d_ax[j];
        d_ay[j+1] <= d_ay[j];
        d_den[j+1] <= d_den[j];
        d_rx[j+1] <= gex ? PPW'(remx - dsh) : d_rx[j];
        d_ry[j+1] <= gey ? PPW'(remy - dsh) : d_ry[j];
        d_qx[j+1] <= d_qx[j] | (NQ'(gex) << (NQ - 1 - j));
        d_qy[j+1] <= d_qy[j] | (NQ'(gey) << (NQ - 1 - j));
      end
    end
  end

  // output stage: point = a + floor(t*r), then round toward zero
  logic                inx, iny;
  logic signed [FW-1:0] flx, fly, sumx, sumy, resx, resy;

  always_comb begin
    inx = d_rx[NQ] != '0;
    iny = d_ry[NQ] != '0;
    flx = d_nx[NQ] ? -(FW'(d_qx[NQ]) + FW'(inx)) : FW'(d_qx[NQ]);
    fly = d_ny[NQ] ? -(FW'(d_qy[NQ]) + FW'(iny)) : FW'(d_qy[NQ]);
    sumx = FW'(d_ax[NQ]) + flx;
    sumy = FW'(d_ay[NQ]) + fly;
    resx = sumx + FW'(inx && sumx[FW-1]);
    resy = sumy + FW'(iny && sumy[FW-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= d_hit[NQ];
      point_x <= d_pt[NQ] ? resx[N-1:0] : '0;
      point_y <= d_pt[NQ] ? resy[N-1:0] : '0;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      for (int k = 0; k <= NQ; k++) begin
        dvld[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      dvld[0] <= v5;
      for (int k = 0; k < NQ; k++) begin
        dvld[k+1] <= dvld[k];
      end
      out_valid <= dvld[NQ];
    end
  end

  a_no_point_on_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> point_x == '0 && point_y == '0)
    else $error("point not zero on a miss");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    dvld[NQ] && en |=> out_valid)
    else $error("divider result lost");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !v1)
    else $error("valid bits not cleared by reset");

endmodule

// ===== verif/tb.sv =====
module tb;

  localparam int CB = sbi_pkg::COORD_BITS_DEF;
  localparam int LATENCY = CB + 8;
  localparam int MAX_CYCLES = 400000;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    sbi_pkg::func_t func;
    coord_t ax, ay, bx, by, x0, y0, x1, y1;
  } query_t;

  typedef struct packed {
    logic   hit;
    coord_t px, py;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = 1'b0;
  coord_t seg_ax = '0, seg_ay = '0, seg_bx = '0, seg_by = '0;
  coord_t other_x0 = '0, other_y0 = '0, other_x1 = '0, other_y1 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  coord_t point_x, point_y;

  query_t pending_q[$];
  answer_t answer_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_hits = 0;
  int cycle = 0;
  int send_idle = 0;
  int recv_stall = 0;

  segment_box_intersection dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .seg_ax(seg_ax), .seg_ay(seg_ay), .seg_bx(seg_bx), .seg_by(seg_by),
    .other_x0(other_x0), .other_y0(other_y0), .other_x1(other_x1), .other_y1(other_y1),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .point_x(point_x), .point_y(point_y)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // 2D cross product, exact at 128 bits
  function automatic logic signed [127:0] cross2(logic signed [127:0] px, logic signed [127:0] py,
                                                 logic signed [127:0] qx, logic signed [127:0] qy);
    return px * qy - py * qx;
  endfunction

  function automatic logic signed [127:0] trunc_div(logic signed [127:0] n,
                                                    logic signed [127:0] d);
    logic signed [127:0] q;
    q = (n < 0 ? -n : n) / d;
    return n < 0 ? -q : q;
  endfunction

  function automatic bit seg_cross(longint ax, longint ay, longint bx, longint by,
                                   longint cx, longint cy, longint dx, longint dy,
                                   output coord_t ix, output coord_t iy);
    logic signed [127:0] rx, ry, sx, sy, qx, qy, den, tn, un;
    rx = bx - ax; ry = by - ay; sx = dx - cx; sy = dy - cy;
    qx = cx - ax; qy = cy - ay;
    den = cross2(rx, ry, sx, sy);
    tn = cross2(qx, qy, sx, sy);
    un = cross2(qx, qy, rx, ry);
    ix = '0;
    iy = '0;
    if (den == 0) return 1'b0;
    if (den < 0) begin
      den = -den; tn = -tn; un = -un;
    end
    if (tn < 0 || tn > den || un < 0 || un > den) return 1'b0;
    ix = coord_t'(trunc_div(ax * den + tn * rx, den));
    iy = coord_t'(trunc_div(ay * den + tn * ry, den));
    return 1'b1;
  endfunction

  function automatic answer_t predict_intersection(query_t q);
    answer_t a;
    longint lx, hx, ly, hy;
    coord_t dx, dy;
    a = '0;
    if (q.func == sbi_pkg::FUNC_SEG) begin
      a.hit = seg_cross(q.ax, q.ay, q.bx, q.by, q.x0, q.y0, q.x1, q.y1, a.px, a.py);
    end else begin
      lx = longint'(q.x0) - q.x1; hx = longint'(q.x0) + q.x1;
      ly = longint'(q.y0) - q.y1; hy = longint'(q.y0) + q.y1;
      a.hit = seg_cross(q.ax, q.ay, q.bx, q.by, lx, ly, hx, ly, dx, dy)
            | seg_cross(q.ax, q.ay, q.bx, q.by, hx, ly, hx, hy, dx, dy)
            | seg_cross(q.ax, q.ay, q.bx, q.by, hx, hy, lx, hy, dx, dy)
            | seg_cross(q.ax, q.ay, q.bx, q.by, lx, hy, lx, ly, dx, dy);
    end
    return a;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch at result %0d: %s got %0d expected %0d", n_checked, what, got, want);
  endtask

  function automatic coord_t rand_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic add_query(sbi_pkg::func_t f, coord_t ax, coord_t ay, coord_t bx, coord_t by,
                           coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    query_t q;
    q.func = f; q.ax = ax; q.ay = ay; q.bx = bx; q.by = by;
    q.x0 = x0; q.y0 = y0; q.x1 = x1; q.y1 = y1;
    pending_q.push_back(q);
  endtask

  // mostly nearby geometry so hits are common; some full-range noise
  task automatic add_random_query();
    int span;
    coord_t cx, cy;
    sbi_pkg::func_t f;
    span = ($urandom_range(0, 9) == 0) ? 0 : (1 << $urandom_range(3, 19)) - 1;
    f = sbi_pkg::func_t'($urandom_range(0, 1));
    cx = rand_coord(span / 2);
    cy = rand_coord(span / 2);
    if (f == sbi_pkg::FUNC_BOX && $urandom_range(0, 7) != 0)
      add_query(f, cx + rand_coord(span / 2), cy + rand_coord(span / 2),
                cx + rand_coord(span / 2), cy + rand_coord(span / 2),
                cx, cy, coord_t'($urandom_range(0, span / 4)),
                coord_t'($urandom_range(0, span / 4)));
    else
      add_query(f, rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
                rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span));
  endtask

  // sender side
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst) begin
      if (in_valid && !in_stall) n_sent <= n_sent + 1;
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          query_t q;
          q = pending_q.pop_front();
          answer_q.push_back(predict_intersection(q));
          in_valid <= 1'b1;
          func <= q.func;
          seg_ax <= q.ax; seg_ay <= q.ay; seg_bx <= q.bx; seg_by <= q.by;
          other_x0 <= q.x0; other_y0 <= q.y0; other_x1 <= q.x1; other_y1 <= q.y1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver side
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          report_mismatch("unexpected transfer", 1, 0);
        end else begin
          answer_t a;
          a = answer_q.pop_front();
          if (hit !== a.hit) report_mismatch("hit", hit, a.hit);
          if (point_x !== a.px) report_mismatch("point_x", point_x, a.px);
          if (point_y !== a.py) report_mismatch("point_y", point_y, a.py);
          if (a.hit) n_hits <= n_hits + 1;
        end
        n_checked <= n_checked + 1;
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall);
    end
  end

  always @(posedge clk) begin
    if (cycle > MAX_CYCLES) begin
      $display("timeout with %0d results outstanding", answer_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    coord_t cmax, cmin;
    cmax = {1'b0, {(CB - 1){1'b1}}};
    cmin = {1'b1, {(CB - 1){1'b0}}};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // crossing, endpoint touch, parallel, collinear, degenerate, extremes, miss
    add_query(sbi_pkg::FUNC_SEG, -160, 0, 160, 0, 0, -160, 0, 160);
    add_query(sbi_pkg::FUNC_SEG, 0, 0, 160, 160, 160, 160, 320, 0);
    add_query(sbi_pkg::FUNC_SEG, 0, 0, 160, 0, 0, 16, 160, 16);
    add_query(sbi_pkg::FUNC_SEG, 0, 0, 160, 0, 80, 0, 240, 0);
    add_query(sbi_pkg::FUNC_SEG, 5, 5, 5, 5, 0, 0, 16, 16);
    add_query(sbi_pkg::FUNC_SEG, 0, 0, 48, 16, 0, 16, 48, 0);
    add_query(sbi_pkg::FUNC_SEG, -7, -3, 11, 5, -9, 4, 13, -6);
    add_query(sbi_pkg::FUNC_SEG, cmin, cmin, cmax, cmax, cmin, cmax, cmax, cmin);
    add_query(sbi_pkg::FUNC_SEG, cmax, cmin, cmin, cmax, cmin, cmin, cmax, cmax);
    add_query(sbi_pkg::FUNC_SEG, cmin, 0, cmax, 0, 0, cmin, 0, cmax);
    add_query(sbi_pkg::FUNC_SEG, 0, 0, 16, 0, 32, -16, 32, 16);
    add_query(sbi_pkg::FUNC_SEG, cmax, cmax, cmax, cmax, cmin, cmin, cmin, cmin);
    // box: through, inside, outside, corner, zero size, negative half sizes, extremes
    add_query(sbi_pkg::FUNC_BOX, -320, 0, 320, 0, 0, 0, 80, 80);
    add_query(sbi_pkg::FUNC_BOX, -16, 0, 16, 0, 0, 0, 80, 80);
    add_query(sbi_pkg::FUNC_BOX, 200, 200, 300, 300, 0, 0, 80, 80);
    add_query(sbi_pkg::FUNC_BOX, 0, 160, 160, 0, 0, 0, 80, 80);
    add_query(sbi_pkg::FUNC_BOX, -16, -16, 16, 16, 0, 0, 0, 0);
    add_query(sbi_pkg::FUNC_BOX, -320, 0, 320, 0, 0, 0, -80, -80);
    add_query(sbi_pkg::FUNC_BOX, cmin, cmin, cmax, cmax, 0, 0, cmax, cmax);
    add_query(sbi_pkg::FUNC_BOX, cmin, 0, cmax, 0, cmax, cmin, cmax, cmax);
    add_query(sbi_pkg::FUNC_BOX, cmax, cmax, cmin, cmin, cmin, cmax, cmin, cmin);
    // four phases of idling: none, sender, receiver, both
    for (int phase = 0; phase < 4; phase++) begin
      send_idle = (phase == 1) ? 45 : (phase == 3) ? 32 : 0;
      recv_stall = (phase == 2) ? 45 : (phase == 3) ? 32 : 0;
      for (int i = 0; i < 110; i++) add_random_query();
      while (pending_q.size() > 0) @(posedge clk);
    end
    while (pending_q.size() > 0 || in_valid || answer_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d queries, %0d results checked, %0d hits", n_sent, n_checked, n_hits);
    $display("segment and box tests under four idle and stall phases");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sbi_pkg.sv
hw/rtl/segment_box_intersection.sv
verif/tb.sv
